### rtl/core/battery_charge_estimator_macros.svh
// Assertion macros used by the battery charge estimator checker.
`ifndef BATTERY_CHARGE_ESTIMATOR_MACROS_SVH
`define BATTERY_CHARGE_ESTIMATOR_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define BCE_ASSERT_ALWAYS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("battery charge estimator check failed");

// Check that a condition holds in the cycle after a trigger.
`define BCE_ASSERT_NEXT(name, clk, rst, trig, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
      else $error("battery charge estimator check failed");

`endif

### rtl/core/bce_pkg.sv
// Shared types, widths, codes and the charge curve of the battery charge estimator.
`timescale 1ns / 1ps
`default_nettype none

package bce_pkg;

   // Stream and register port widths
   localparam int unsigned REQ_TDATA_W = 48;
   localparam int unsigned REQ_TUSER_W = 1;
   localparam int unsigned RSP_TDATA_W = 24;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 32;

   // Field widths
   localparam int unsigned TIME_W = 32;
   localparam int unsigned PIN_W  = 12;
   localparam int unsigned GAIN_W = 16;
   localparam int unsigned MV_W   = 16;
   localparam int unsigned PCT_W  = 7;
   localparam int unsigned COEF_W = 16;
   localparam int unsigned STEP_W = 5;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_INTERVAL = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLTAGE_GAIN    = 8'd1;

   localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd60000;
   localparam logic [GAIN_W-1:0] GAIN_RESET     = 16'd8192;

   // Average weights, Q16
   localparam logic [COEF_W-1:0] ALPHA_Q16           = 16'd9830;
   localparam logic [COEF_W-1:0] ONE_MINUS_ALPHA_Q16 = 16'd55706;
   localparam logic [STEP_W-1:0] FILTER_LAST_STEP    = 5'd15;

   localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;
   localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;

   // Charge curve: millivolts against percent, rising
   localparam int unsigned SOC_POINTS = 14;
   localparam logic [MV_W-1:0] SOC_MV [SOC_POINTS] = '{
      16'd3300, 16'd3500, 16'd3600, 16'd3650, 16'd3700, 16'd3730, 16'd3770,
      16'd3820, 16'd3880, 16'd3950, 16'd4030, 16'd4100, 16'd4150, 16'd4200
   };
   localparam logic [PCT_W-1:0] SOC_PCT [SOC_POINTS] = '{
      7'd0, 7'd5, 7'd10, 7'd15, 7'd20, 7'd30, 7'd40,
      7'd50, 7'd60, 7'd70, 7'd80, 7'd90, 7'd95, 7'd100
   };

   // Command to the serial multiply-accumulate unit
   typedef struct packed {
      logic              start;
      logic [COEF_W-1:0] coef_a;
      logic [COEF_W-1:0] coef_b;
      logic [STEP_W-1:0] last_step;
      logic [STEP_W-1:0] round_step;
   } bce_mac_cmd_type;

endpackage

`default_nettype wire

### rtl/core/bce_shift_mac.sv
// Bit-serial dual multiply-accumulate with right shift and half-up rounding.
`timescale 1ns / 1ps
`default_nettype none

module bce_shift_mac #(
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bce_pkg::bce_mac_cmd_type  cmd,
   input  logic [FRAC_BITS+11:0]     x_value,
   input  logic [FRAC_BITS+11:0]     y_value,
   output logic                      done,
   output logic [FRAC_BITS+12:0]     result
);
   import bce_pkg::*;

   localparam int unsigned VW = FRAC_BITS + 12;

   logic [VW-1:0]     x_ff;
   logic [VW-1:0]     y_ff;
   logic [COEF_W-1:0] a_ff;
   logic [COEF_W-1:0] b_ff;
   logic [STEP_W-1:0] last_ff;
   logic [STEP_W-1:0] round_ff;
   logic [VW:0]       acc_ff;
   logic [VW:0]       acc_in;
   logic [VW+1:0]     sum;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;

   // One coefficient bit per step; the low sum bit drops out each cycle while busy
   always_comb begin
      sum = {1'b0, acc_ff}
          + (a_ff[0] ? {2'b00, x_ff} : '0)
          + (b_ff[0] ? {2'b00, y_ff} : '0)
          + {{(VW+1){1'b0}}, (step_ff == round_ff)};
      acc_in = sum[VW+1:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            if (step_ff == last_ff) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff + STEP_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         x_ff     <= x_value;
         y_ff     <= y_value;
         a_ff     <= cmd.coef_a;
         b_ff     <= cmd.coef_b;
         last_ff  <= cmd.last_step;
         round_ff <= cmd.round_step;
         acc_ff   <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         a_ff   <= {1'b0, a_ff[COEF_W-1:1]};
         b_ff   <= {1'b0, b_ff[COEF_W-1:1]};
      end
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

`default_nettype wire

### rtl/core/bce_soc_lookup.sv
// Charge curve lookup: segment scan and serial half-up interpolation divide.
`timescale 1ns / 1ps
`default_nettype none

module bce_soc_lookup (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bce_pkg::MV_W-1:0]    mv,
   output logic                        done,
   output logic [bce_pkg::PCT_W-1:0]   pct
);
   import bce_pkg::*;

   localparam int unsigned SEG_W = $clog2(SOC_POINTS);
   localparam int unsigned NUM_W = MV_W + PCT_W + 2;
   localparam int unsigned QUO_W = PCT_W;
   localparam int unsigned CNT_W = $clog2(QUO_W);
   localparam logic [SEG_W-1:0] LAST_SEG = SEG_W'(SOC_POINTS - 2);

   typedef enum logic [1:0] {LK_IDLE, LK_SCAN, LK_DIV} lk_state_type;

   lk_state_type     state_ff;
   logic [SEG_W-1:0] seg_ff;
   logic [SEG_W-1:0] seg_next;
   logic [NUM_W-1:0] rem_ff;
   logic [NUM_W-1:0] dsh_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [PCT_W-1:0] plo_ff;
   logic [PCT_W-1:0] pct_ff;
   logic             done_ff;

   logic [MV_W-1:0]  lo;
   logic [MV_W-1:0]  hi;
   logic [PCT_W-1:0] plo;
   logic [PCT_W-1:0] phi;
   logic [PCT_W-1:0] dp;
   logic [MV_W-1:0]  dv;
   logic [MV_W-1:0]  dmv;
   logic [NUM_W-1:0] num;
   logic [NUM_W-1:0] dsh_start;
   logic             hit;
   logic             ge;
   logic [QUO_W-1:0] quo_final;
   logic [PCT_W:0]   pct_sum;
   logic [PCT_W-1:0] pct_clamped;

   always_comb begin
      seg_next  = seg_ff + SEG_W'(1);
      lo        = SOC_MV[seg_ff];
      hi        = SOC_MV[seg_next];
      plo       = SOC_PCT[seg_ff];
      phi       = SOC_PCT[seg_next];
      dp        = (phi >= plo) ? (phi - plo) : '0;
      dv        = hi - lo;
      dmv       = mv - lo;
      num       = ((NUM_W'(dmv) * NUM_W'(dp)) << 1) + NUM_W'(dv);
      dsh_start = NUM_W'({dv, 1'b0}) << (QUO_W - 1);
      hit       = (mv <= hi) && (hi > lo);
      ge        = (rem_ff >= dsh_ff);
      quo_final = {quo_ff[QUO_W-2:0], ge};
      pct_sum   = {1'b0, plo_ff} + {1'b0, quo_final};
      pct_clamped = (pct_sum > {1'b0, PCT_FULL}) ? PCT_FULL : pct_sum[PCT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LK_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            LK_IDLE: begin
               if (start) begin
                  priority if (mv >= SOC_MV[SOC_POINTS-1]) begin
                     pct_ff  <= PCT_FULL;
                     done_ff <= 1'b1;
                  end else if (mv <= SOC_MV[0]) begin
                     pct_ff  <= PCT_EMPTY;
                     done_ff <= 1'b1;
                  end else begin
                     seg_ff   <= '0;
                     state_ff <= LK_SCAN;
                  end
               end
            end
            LK_SCAN: begin
               priority if (hit) begin
                  rem_ff   <= num;
                  dsh_ff   <= dsh_start;
                  plo_ff   <= plo;
                  quo_ff   <= '0;
                  cnt_ff   <= CNT_W'(QUO_W - 1);
                  state_ff <= LK_DIV;
               end else if (seg_ff == LAST_SEG) begin
                  pct_ff   <= PCT_EMPTY;
                  done_ff  <= 1'b1;
                  state_ff <= LK_IDLE;
               end else begin
                  seg_ff <= seg_next;
               end
            end
            LK_DIV: begin
               if (ge) begin
                  rem_ff <= rem_ff - dsh_ff;
               end
               quo_ff <= quo_final;
               dsh_ff <= {1'b0, dsh_ff[NUM_W-1:1]};
               if (cnt_ff == '0) begin
                  pct_ff   <= pct_clamped;
                  done_ff  <= 1'b1;
                  state_ff <= LK_IDLE;
               end else begin
                  cnt_ff <= cnt_ff - CNT_W'(1);
               end
            end
            default: begin
               state_ff <= LK_IDLE;
            end
         endcase
      end
   end

   assign done = done_ff;
   assign pct  = pct_ff;

endmodule

`default_nettype wire

### rtl/core/battery_charge_estimator.sv
// Top level of the battery charge estimator: sample gate, average, scaling, charge lookup.
// An ignored item (interval not elapsed or motor busy) gives no result; an accepted item
// raises rsp_tvalid after its transfer once it has passed 16 average steps,
// FILTER_FRAC_BITS + 12 scaling steps, the segment scan and 7 divide steps;
// a seeded average skips the average steps. Throughput: one item in work, req_tready returns
// once the result loads the output register. Reset: synchronous, active high, clears state.
`timescale 1ns / 1ps
`default_nettype none

module battery_charge_estimator #(
   parameter int unsigned FILTER_FRAC_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // Input stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // req_tdata: now_ms [31:0], pin_mv [43:32], zero pad [47:44]
   input  logic [bce_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // req_tuser: motor_busy [0]
   input  logic [bce_pkg::REQ_TUSER_W-1:0]    req_tuser,
   // Result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // rsp_tdata: battery_mv [15:0], charge_pct [22:16], zero pad [23]
   output logic [bce_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // Register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bce_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bce_pkg::CSR_DATA_W-1:0]     csr_data
);
   import bce_pkg::*;

   // Average width: pin millivolts plus fraction bits
   localparam int unsigned VW = PIN_W + FILTER_FRAC_BITS;
   localparam logic [VW+3:0] SEED_LIMIT = (VW+4)'(1) << FILTER_FRAC_BITS;
   localparam logic [STEP_W-1:0] SCALE_LAST_STEP = STEP_W'(FILTER_FRAC_BITS + 11);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILTER,
      ST_SCALE_START,
      ST_SCALE,
      ST_LOOKUP_START,
      ST_LOOKUP,
      ST_EMIT
   } state_type;

   state_type             state_ff;
   logic [TIME_W-1:0]     interval_ff;
   logic [GAIN_W-1:0]     gain_ff;
   logic [TIME_W-1:0]     last_time_ff;
   logic [VW-1:0]         filt_ff;
   logic [MV_W-1:0]       mv_ff;
   logic                  rsp_tvalid_ff;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;

   logic [TIME_W-1:0]     now_ms;
   logic [PIN_W-1:0]      pin_mv;
   logic                  motor_busy;
   logic [TIME_W-1:0]     elapsed;
   logic                  req_accept;
   logic                  take;
   logic [VW-1:0]         pin_fx;
   logic [VW+3:0]         filt_times10;
   logic                  seed;
   logic                  out_free;
   logic [MV_W-1:0]       mv_sat;

   bce_mac_cmd_type       mac_cmd;
   logic                  mac_done;
   logic [VW:0]           mac_result;
   logic                  lut_done;
   logic [PCT_W-1:0]      lut_pct;

   // Unpack the request fields
   assign now_ms     = req_tdata[TIME_W-1:0];
   assign pin_mv     = req_tdata[TIME_W+PIN_W-1:TIME_W];
   assign motor_busy = req_tuser[0];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      // Wrapping time difference against the interval; a busy motor defers the sample
      elapsed      = now_ms - last_time_ff;
      take         = (elapsed >= interval_ff) && !motor_busy;
      pin_fx       = {pin_mv, {FILTER_FRAC_BITS{1'b0}}};
      // Seed while the average sits at or below a tenth of a millivolt
      filt_times10 = ((VW+4)'(filt_ff) << 3) + ((VW+4)'(filt_ff) << 1);
      seed         = (filt_times10 <= SEED_LIMIT);
      // Scaled value never gets near the top in practice; clamp anyway
      mv_sat = (mac_result[VW:MV_W] != '0) ? {MV_W{1'b1}} : mac_result[MV_W-1:0];
   end

   // Drive the serial unit: weighted average from idle, gain scaling afterwards
   always_comb begin
      mac_cmd.start = ((state_ff == ST_IDLE) && req_accept && take && !seed)
                    || (state_ff == ST_SCALE_START);
      if (state_ff == ST_IDLE) begin
         mac_cmd.coef_a     = ONE_MINUS_ALPHA_Q16;
         mac_cmd.coef_b     = ALPHA_Q16;
         mac_cmd.last_step  = FILTER_LAST_STEP;
         mac_cmd.round_step = FILTER_LAST_STEP;
      end else begin
         mac_cmd.coef_a     = gain_ff;
         mac_cmd.coef_b     = '0;
         mac_cmd.last_step  = SCALE_LAST_STEP;
         mac_cmd.round_step = SCALE_LAST_STEP;
      end
   end

   bce_shift_mac #(
      .FRAC_BITS (FILTER_FRAC_BITS)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mac_cmd),
      .x_value (filt_ff),
      .y_value (pin_fx),
      .done    (mac_done),
      .result  (mac_result)
   );

   bce_soc_lookup u_lookup (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_LOOKUP_START),
      .mv    (mv_ff),
      .done  (lut_done),
      .pct   (lut_pct)
   );

   // Register writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
         gain_ff     <= GAIN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SAMPLE_INTERVAL: interval_ff <= csr_data[TIME_W-1:0];
            CSR_VOLTAGE_GAIN:    gain_ff     <= csr_data[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer with sample state and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_time_ff  <= '0;
         filt_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // Drop the result once its transfer completes; in ST_EMIT the load below decides
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_EMIT)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept && take) begin
                  last_time_ff <= now_ms;
                  if (seed) begin
                     filt_ff  <= pin_fx;
                     state_ff <= ST_SCALE_START;
                  end else begin
                     state_ff <= ST_FILTER;
                  end
               end
            end
            ST_FILTER: begin
               if (mac_done) begin
                  filt_ff  <= mac_result[VW-1:0];
                  state_ff <= ST_SCALE_START;
               end
            end
            ST_SCALE_START: begin
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               if (mac_done) begin
                  mv_ff    <= mv_sat;
                  state_ff <= ST_LOOKUP_START;
               end
            end
            ST_LOOKUP_START: begin
               state_ff <= ST_LOOKUP;
            end
            ST_LOOKUP: begin
               if (lut_done) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               // Hold until the output register is free, then load it
               if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= {1'b0, lut_pct, mv_ff};
                  state_ff      <= ST_IDLE;
               end else begin
                  rsp_tvalid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire

### rtl/core/bce_checker.sv
// Port-level checks of the battery charge estimator and their bind.
`timescale 1ns / 1ps
`default_nettype none

`include "battery_charge_estimator_macros.svh"

module bce_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [bce_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import bce_pkg::*;

   logic                  req_transfer;
   logic [MV_W-1:0]       rsp_mv;
   logic [PCT_W-1:0]      rsp_pct;
   logic                  at_top;

   assign req_transfer = req_tvalid && req_tready;
   assign rsp_mv       = rsp_tdata[MV_W-1:0];
   assign rsp_pct      = rsp_tdata[MV_W+PCT_W-1:MV_W];
   assign at_top       = (rsp_mv >= SOC_MV[SOC_POINTS-1]);

   // Percent never leaves the curve range
   `BCE_ASSERT_ALWAYS(a_pct_range, clock, reset, !rsp_tvalid || (rsp_pct <= PCT_FULL))

   // A voltage at the top of the curve reads as full charge
   `BCE_ASSERT_ALWAYS(a_full_at_top, clock, reset, !rsp_tvalid || !at_top || (rsp_pct == PCT_FULL))

   // No result can appear in the cycle right after an input transfer
   `BCE_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_transfer, !$rose(rsp_tvalid))

   // A stalled result holds
   `BCE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind battery_charge_estimator bce_checker u_bce_checker (.*);

`default_nettype wire
